### hdl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted
`define ASSERT_RST(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

### hdl/ctr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_pkg
// Constants, types and tables of the circular reference generator.
// ----------------------------------------------------------------------------
package ctr_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int ITERS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

	// register indexes
	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_RADIUS   = 2'd2;
	localparam logic [1:0] REG_PERIOD   = 2'd3;

	localparam logic [31:0] CENTER_RESET = 32'd0;
	localparam logic [30:0] RADIUS_RESET = 31'd65536;
	localparam logic [31:0] RATE_RESET   = 32'd41177;

	// 2*pi in Q32, its split form, and multiples for the reduction
	localparam logic [35:0] TWO_PI_Q32 = 36'd26986075409;
	localparam logic [30:0] TWO_PI_LO  = 31'd1216271633;
	localparam logic [37:0] TWO_PI_X1  = 38'd26986075409;
	localparam logic [37:0] TWO_PI_X2  = 38'd53972150818;
	localparam logic [37:0] TWO_PI_X4  = 38'd107944301636;
	// floor(2^64 / 2pi_q32), slightly low so the quotient estimate never overshoots
	localparam logic [29:0] RECIP_M    = 30'd683565275;

	localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
	localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
	localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;

	localparam logic [29:0] KINV_Q30 = 30'h26DD3B6A;

	localparam logic [5:0] DIV_BITS = 6'd36;

	localparam logic [29:0] ATAN_TAB [10] = '{
		30'h3243F6A9, 30'h1DAC6705, 30'h0FADBAFD, 30'h07F56EA7, 30'h03FEAB77,
		30'h01FFD55C, 30'h00FFFAAB, 30'h007FFF55, 30'h003FFFEB, 30'h001FFFFD
	};

	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [33:0] z;
		logic               flip;
		logic [31:0]        head;
		logic [31:0]        spd;
		logic [31:0]        rate;
	} ctr_rot_t;

	function automatic logic signed [33:0] atan_entry(input int i);
		logic signed [33:0] r;
		r = '0;
		if (i < 10) begin
			r = signed'({4'b0000, ATAN_TAB[i]});
		end else if (i <= 30) begin
			r = 34'sd1 <<< (30 - i);
		end
		return r;
	endfunction

endpackage

### hdl/ctr_rate_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_rate_div
// Bit-serial divider: rate = round(2pi_q32 / period), saturated to 32 bits.
// ----------------------------------------------------------------------------
module ctr_rate_div
	import ctr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] period,
	output logic [31:0] rate,
	output logic        busy
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [35:0] num_q;
	logic [31:0] rem_q;
	logic [35:0] quo_q;
	logic [31:0] den_q;
	logic [31:0] rate_q;
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	logic        ge;

	assign rem_sh  = {rem_q, num_q[35]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rate_q <= RATE_RESET;
		end else if (start) begin
			if (period == 32'd0) begin
				rate_q <= '1;
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end else if (busy_q) begin
			if (cnt_q == DIV_BITS) begin
				rate_q <= (quo_q[35:32] != 4'd0) ? '1 : quo_q[31:0];
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= TWO_PI_Q32 + {5'd0, period[31:1]};
			den_q <= period;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q && cnt_q != DIV_BITS) begin
			rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[34:0], ge};
			num_q <= {num_q[34:0], 1'b0};
		end
	end

	assign rate = rate_q;
	assign busy = busy_q;

endmodule

### hdl/ctr_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_phase
// Phase front end: k*t, reduction modulo 2pi, heading, quadrant fold, speed.
// ----------------------------------------------------------------------------
module ctr_phase
	import ctr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] time_s,
	input  logic [31:0] rate,
	input  logic [30:0] radius,
	output logic        out_valid,
	input  logic        out_ready,
	output ctr_rot_t    out_data
);

	logic [9:1] v_s;
	logic [10:1] en;

	logic [63:0] p_s1;
	logic [62:0] kr_s1;
	logic [31:0] k_s1;

	logic [29:0] qe_s2;
	logic [37:0] plo_s2;
	logic [31:0] spd_s2;
	logic [31:0] k_s2;

	logic [60:0] m_s3;
	logic [5:0]  qh_s3;
	logic [37:0] plo_s3;
	logic [31:0] spd_s3;
	logic [31:0] k_s3;

	logic [37:0] r_s4, r_s5, r_s6, r_s7;
	logic [31:0] spd_s4, spd_s5, spd_s6, spd_s7, spd_s8;
	logic [31:0] k_s4, k_s5, k_s6, k_s7, k_s8;

	logic signed [33:0] a_s8;
	logic signed [63:0] x0_s8;

	ctr_rot_t rot_s9;

	logic [61:0] qprod;
	logic [63:0] kr_rnd;
	logic [32:0] qh6;
	logic [35:0] a_rnd;
	logic signed [33:0] a_raw;
	logic signed [33:0] h_sum;
	logic signed [33:0] a_fold;
	logic               flip;

	// a stage takes a new item when empty or when its successor moves
	always_comb begin
		en[10] = out_ready;
		for (int i = 9; i >= 1; i--) begin
			en[i] = !v_s[i] || en[i+1];
		end
	end
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[1]) v_s[1] <= in_valid;
			for (int i = 2; i <= 9; i++) begin
				if (en[i]) v_s[i] <= v_s[i-1];
			end
		end
	end

	assign qprod  = p_s1[63:32] * RECIP_M;
	assign kr_rnd = {1'b0, kr_s1} + 64'd32768;
	assign qh6    = {1'b0, qe_s2, 2'b00} + {2'b00, qe_s2, 1'b0};
	assign a_rnd  = {1'b0, r_s7[34:0]} + 36'd4;
	assign a_raw  = signed'({1'b0, a_rnd[35:3]});

	always_comb begin
		h_sum = a_s8 + HALF_PI_Q29;
		if (h_sum > PI_Q29) h_sum = h_sum - TWO_PI_Q29;
	end

	always_comb begin
		a_fold = a_s8;
		flip   = 1'b0;
		if (a_s8 > HALF_PI_Q29) begin
			a_fold = a_s8 - PI_Q29;
			flip   = 1'b1;
		end else if (a_s8 < -HALF_PI_Q29) begin
			a_fold = a_s8 + PI_Q29;
			flip   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s1  <= rate * time_s;
			kr_s1 <= rate * radius;
			k_s1  <= rate;
		end
		if (en[2]) begin
			qe_s2  <= qprod[61:32];
			plo_s2 <= p_s1[37:0];
			spd_s2 <= (kr_rnd[63:48] != 16'd0) ? '1 : kr_rnd[47:16];
			k_s2   <= k_s1;
		end
		if (en[3]) begin
			m_s3   <= qe_s2 * TWO_PI_LO;
			qh_s3  <= qh6[5:0];
			plo_s3 <= plo_s2;
			spd_s3 <= spd_s2;
			k_s3   <= k_s2;
		end
		if (en[4]) begin
			// only the low bits matter: the remainder stays below 8 * 2pi
			r_s4   <= plo_s3 - m_s3[37:0] - {qh_s3, 32'd0};
			spd_s4 <= spd_s3;
			k_s4   <= k_s3;
		end
		if (en[5]) begin
			r_s5   <= (r_s4 >= TWO_PI_X4) ? r_s4 - TWO_PI_X4 : r_s4;
			spd_s5 <= spd_s4;
			k_s5   <= k_s4;
		end
		if (en[6]) begin
			r_s6   <= (r_s5 >= TWO_PI_X2) ? r_s5 - TWO_PI_X2 : r_s5;
			spd_s6 <= spd_s5;
			k_s6   <= k_s5;
		end
		if (en[7]) begin
			r_s7   <= (r_s6 >= TWO_PI_X1) ? r_s6 - TWO_PI_X1 : r_s6;
			spd_s7 <= spd_s6;
			k_s7   <= k_s6;
		end
		if (en[8]) begin
			a_s8   <= (a_raw > PI_Q29) ? a_raw - TWO_PI_Q29 : a_raw;
			x0_s8  <= signed'({3'b000, 61'(radius) * 61'(KINV_Q30)});
			spd_s8 <= spd_s7;
			k_s8   <= k_s7;
		end
		if (en[9]) begin
			rot_s9.x    <= x0_s8;
			rot_s9.y    <= '0;
			rot_s9.z    <= a_fold <<< 1;
			rot_s9.flip <= flip;
			rot_s9.head <= h_sum[31:0];
			rot_s9.spd  <= spd_s8;
			rot_s9.rate <= k_s8;
		end
	end

	assign out_valid = v_s[9];
	assign out_data  = rot_s9;

endmodule

### hdl/ctr_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_cordic
// Unrolled rotation CORDIC, one iteration per stage, then rounding and the
// center offset with saturation.
// ----------------------------------------------------------------------------
module ctr_cordic
	import ctr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ctr_rot_t    in_data,
	input  logic [31:0] ofs_x,
	input  logic [31:0] ofs_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pos_x,
	output logic [31:0] pos_y,
	output logic [31:0] heading,
	output logic [31:0] linear_speed,
	output logic [31:0] angular_speed
);

	localparam int RND = ITERS + 1;
	localparam int FIN = ITERS + 2;

	logic [FIN:1]   v_s;
	logic [FIN+1:1] en;
	ctr_rot_t       stg_s [1:ITERS];

	logic signed [33:0] xr_s, yr_s;
	logic [31:0]        head_r_s, spd_r_s, rate_r_s;
	logic [31:0]        px_s, py_s, head_s, spd_s, rate_s;

	logic signed [63:0] xf, yf;
	logic signed [63:0] rnd_add;
	logic signed [63:0] xsum, ysum;
	logic signed [34:0] cxs, cys;

	always_comb begin
		en[FIN+1] = out_ready;
		for (int i = FIN; i >= 1; i--) begin
			en[i] = !v_s[i] || en[i+1];
		end
	end
	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[1]) v_s[1] <= in_valid;
			for (int i = 2; i <= FIN; i++) begin
				if (en[i]) v_s[i] <= v_s[i-1];
			end
		end
	end

	for (genvar g = 1; g <= ITERS; g++) begin : g_iter
		localparam int SH = g - 1;
		ctr_rot_t src;
		ctr_rot_t nxt;
		if (g == 1) begin : g_first
			assign src = in_data;
		end else begin : g_rest
			assign src = stg_s[g-1];
		end
		always_comb begin
			nxt = src;
			if (src.z >= 0) begin
				nxt.x = src.x - (src.y >>> SH);
				nxt.y = src.y + (src.x >>> SH);
				nxt.z = src.z - atan_entry(SH);
			end else begin
				nxt.x = src.x + (src.y >>> SH);
				nxt.y = src.y - (src.x >>> SH);
				nxt.z = src.z + atan_entry(SH);
			end
		end
		always_ff @(posedge clk) begin
			if (en[g]) stg_s[g] <= nxt;
		end
	end

	// negate on a flip as ~v + 1, folded into the rounding constant
	assign xf      = stg_s[ITERS].flip ? ~stg_s[ITERS].x : stg_s[ITERS].x;
	assign yf      = stg_s[ITERS].flip ? ~stg_s[ITERS].y : stg_s[ITERS].y;
	assign rnd_add = stg_s[ITERS].flip ? 64'sd536870913 : 64'sd536870912;
	assign xsum    = xf + rnd_add;
	assign ysum    = yf + rnd_add;

	assign cxs = signed'({ofs_x[31], ofs_x[31], ofs_x[31], ofs_x})
		+ {xr_s[33], xr_s};
	assign cys = signed'({ofs_y[31], ofs_y[31], ofs_y[31], ofs_y})
		+ {yr_s[33], yr_s};

	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		logic [31:0] r;
		r = v[31:0];
		if (v > 35'sd2147483647) r = 32'h7FFFFFFF;
		else if (v < -35'sd2147483648) r = 32'h80000000;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en[RND]) begin
			xr_s     <= xsum[63:30];
			yr_s     <= ysum[63:30];
			head_r_s <= stg_s[ITERS].head;
			spd_r_s  <= stg_s[ITERS].spd;
			rate_r_s <= stg_s[ITERS].rate;
		end
		if (en[FIN]) begin
			px_s   <= sat32(cxs);
			py_s   <= sat32(cys);
			head_s <= head_r_s;
			spd_s  <= spd_r_s;
			rate_s <= rate_r_s;
		end
	end

	assign out_valid     = v_s[FIN];
	assign pos_x         = px_s;
	assign pos_y         = py_s;
	assign heading       = head_s;
	assign linear_speed  = spd_s;
	assign angular_speed = rate_s;

endmodule

### hdl/circular_trajectory_reference_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_trajectory_reference_core
// Reference pose and speeds of a point that laps a circle at constant rate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / time_s) takes one Q16.16 time per
//   item; output channel (out_valid / out_stall) returns position, heading,
//   linear and angular speed for it, in order, one result per item.
//   Throughput is one item per clock while in_stall is low; the pipeline is
//   nine phase stages, one stage per CORDIC iteration, then rounding and
//   the center add.
//   The config port (cfg_wr_en / cfg_index / cfg_data) writes center,
//   radius and lap period. A nonzero period write starts a bit-serial
//   divide for the rate; in_stall stays high until it ends.
//   Reset loads center 0, radius 1.0, period 10.0 and its rate, and empties
//   the pipeline. When the receiver stalls, the output item holds and the
//   stages behind it keep filling their empty slots; the stall reaches
//   in_stall only once every stage holds an item.
// ----------------------------------------------------------------------------
module circular_trajectory_reference_core
	import ctr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] time_s,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pos_x,
	output logic [31:0] pos_y,
	output logic [31:0] heading,
	output logic [31:0] linear_speed,
	output logic [31:0] angular_speed,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] cx_q;
	logic [31:0] cy_q;
	logic [30:0] rad_q;
	logic [31:0] rate;
	logic        div_busy;
	logic        ph_ready;
	logic        ph_valid;
	logic        cor_ready;
	ctr_rot_t    ph_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= CENTER_RESET;
			cy_q  <= CENTER_RESET;
			rad_q <= RADIUS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CENTER_X: cx_q  <= cfg_data;
				REG_CENTER_Y: cy_q  <= cfg_data;
				REG_RADIUS:   rad_q <= cfg_data[30:0];
				REG_PERIOD:   ;
			endcase
		end
	end

	ctr_rate_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr_en && cfg_index == REG_PERIOD),
		.period (cfg_data),
		.rate   (rate),
		.busy   (div_busy)
	);

	assign in_stall = div_busy || !ph_ready;

	ctr_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid && !div_busy),
		.in_ready  (ph_ready),
		.time_s    (time_s),
		.rate      (rate),
		.radius    (rad_q),
		.out_valid (ph_valid),
		.out_ready (cor_ready),
		.out_data  (ph_data)
	);

	ctr_cordic u_cordic (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (ph_valid),
		.in_ready      (cor_ready),
		.in_data       (ph_data),
		.ofs_x         (cx_q),
		.ofs_y         (cy_q),
		.out_valid     (out_valid),
		.out_ready     (!out_stall),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.heading       (heading),
		.linear_speed  (linear_speed),
		.angular_speed (angular_speed)
	);

endmodule

### hdl/ctr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_checker
// Port-level checks of the circular reference generator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctr_checker
	import ctr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [31:0] time_s,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] pos_x,
	input logic [31:0] pos_y,
	input logic [31:0] heading,
	input logic [31:0] linear_speed,
	input logic [31:0] angular_speed,
	input logic        cfg_wr_en,
	input logic [1:0]  cfg_index,
	input logic [31:0] cfg_data
);

	`ASSERT_RST(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(heading), "stalled output item changed")
	`ASSERT_RST(a_div_stall, clk, arst_n, cfg_wr_en && cfg_index == REG_PERIOD && cfg_data != 32'd0 |=> in_stall, "input taken while rate divide runs")
	`ASSERT_RST(a_head_range, clk, arst_n, out_valid |-> $signed(heading) > -32'sd1686629713 && $signed(heading) <= 32'sd1686629713, "heading outside (-pi, pi]")
	`ASSERT_ALWAYS(a_rst_empty, clk, !arst_n |-> !out_valid, "output valid during reset")

endmodule

bind circular_trajectory_reference_core ctr_checker u_ctr_checker (.*);
